// ===== src/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants for the rolling median filter
// Transaction payload structs and the fixed field widths of the channels.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

  // Field widths fixed by the channel definitions
  localparam int SAMPLE_BITS    = 16;
  localparam int LEN_BITS       = 5;
  localparam int COUNT_BITS     = 5;

  // Defaults for the top-level parameter and the length register
  localparam int MAX_WINDOW_DEF = 16;
  localparam int LEN_RESET      = 16;

  // Input transaction
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } sample_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] median;
    logic        [COUNT_BITS-1:0]  fill_count;
  } result_t;

endpackage

`default_nettype wire

// ===== src/rolling_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// rolling_median_filter_unit: running median over a ring window of samples
// Keeps the window both in arrival order (ring RAM) and sorted (ping-pong
// RAM). Each sample drops the evicted value from the sorted list and merges
// the new one in, in a single pass through one shared comparator.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------
//  sample   | in        | sample_valid/sample_stall | sample_in_t
//  result   | out       | result_valid/result_stall | result_t
//  cfg      | in        | cfg_we (no wait)          | cfg_wdata (length)
//
//  After accept a transaction steps through load, fetch of the evicted value,
//  the sorted-list pass and the final step before the next accept; the pass
//  reads one entry per cycle through the one comparator.
//  The input is stalled while a sample is in work; a waiting result stalls
//  only the final step of the next one.
//  Reset is synchronous; it empties the window, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_median_filter_unit
  import rmf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire sample_in_t          sample_data,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output result_t                  result_data,
  input  wire logic                cfg_we,
  input  wire logic [LEN_BITS-1:0] cfg_wdata
);

  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = $clog2(2 * MAX_WINDOW);
  localparam int LEN_RESET_EFF = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_OLD   = 5'b00100,
    S_PASS  = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t state;

  // Window bookkeeping
  logic [CW-1:0] eff_len;
  logic [IW-1:0] write_pos;
  logic [CW-1:0] valid_count;
  logic          bank;

  // Per-transaction working registers
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SAMPLE_BITS-1:0] carry;
  logic signed [SAMPLE_BITS-1:0] med;
  logic [CW-1:0] c0;
  logic [IW-1:0] wp0;
  logic          evict;
  logic          removed;
  logic [CW-1:0] rd_idx;
  logic          rd_pend;
  logic [CW-1:0] wr_idx;

  // RAM ports
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic                   ring_we;
  logic [SAMPLE_BITS-1:0] sort_rdata;
  logic                   sort_we;
  logic [SW-1:0]          sort_raddr;
  logic [SW-1:0]          sort_waddr;
  logic [SAMPLE_BITS-1:0] sort_wdata;

  // Pass datapath
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] emit;
  logic          skip;
  logic          lt;
  logic          issue;
  logic [CW-1:0] mid_idx;
  logic [CW-1:0] c0_fill;
  logic [CW-1:0] n_new;
  logic [IW-1:0] wp_next;
  logic          accept;
  logic          out_free;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;
  assign mid_idx      = valid_count >> 1;
  assign issue        = (rd_idx < c0);
  assign c0_fill      = sample_data.restart ? '0 : valid_count;
  assign n_new        = evict ? c0 : c0 + CW'(1);
  assign wp_next      = (CW'(wp0) + CW'(1) == eff_len) ? '0 : wp0 + IW'(1);

  // Shared comparator: drop the evicted value once, keep the larger in carry
  always_comb begin
    x    = $signed(sort_rdata);
    skip = !removed && (x == old_val);
    lt   = (x < carry);
    emit = lt ? x : carry;
  end

  // Sorted RAM: read from the current bank, write the merged list to the other
  always_comb begin
    sort_raddr = bank ? (SW'(rd_idx) + SW'(MAX_WINDOW)) : SW'(rd_idx);
    sort_we    = 1'b0;
    sort_wdata = emit;
    if (state == S_FINAL) begin
      sort_we    = out_free;
      sort_wdata = carry;
    end else if (state == S_PASS) begin
      sort_we    = rd_pend && !skip;
    end
    sort_waddr = bank ? SW'(wr_idx) : (SW'(wr_idx) + SW'(MAX_WINDOW));
  end

  assign ring_we = (state == S_OLD);

  rmf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(wp0),
    .wdata(smp),
    .raddr(wp0),
    .rdata(ring_rdata)
  );

  rmf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(2 * MAX_WINDOW)
  ) u_sorted (
    .clk  (clk),
    .we   (sort_we),
    .waddr(sort_waddr),
    .wdata(sort_wdata),
    .raddr(sort_raddr),
    .rdata(sort_rdata)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      eff_len      <= CW'(LEN_RESET_EFF);
      write_pos    <= '0;
      valid_count  <= '0;
      bank         <= 1'b0;
      result_valid <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          eff_len <= CW'(1);
        end else if (int'(cfg_wdata) > MAX_WINDOW) begin
          eff_len <= CW'(MAX_WINDOW);
        end else begin
          eff_len <= CW'(cfg_wdata);
        end
        write_pos   <= '0;
        valid_count <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_OLD;
        end
        S_OLD: begin
          write_pos   <= wp_next;
          valid_count <= n_new;
          rd_pend     <= 1'b0;
          state       <= S_PASS;
        end
        S_PASS: begin
          rd_pend <= issue;
          if (!issue && !rd_pend) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            result_valid <= 1'b1;
            bank         <= ~bank;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          smp   <= sample_data.sample;
          c0    <= c0_fill;
          wp0   <= sample_data.restart ? '0 : write_pos;
          evict <= (c0_fill == eff_len);
        end
      end
      S_OLD: begin
        old_val <= $signed(ring_rdata);
        carry   <= smp;
        removed <= !evict;
        rd_idx  <= '0;
        wr_idx  <= '0;
      end
      S_PASS: begin
        if (issue) begin
          rd_idx <= rd_idx + CW'(1);
        end
        if (rd_pend) begin
          if (skip) begin
            removed <= 1'b1;
          end else begin
            carry  <= lt ? carry : x;
            wr_idx <= wr_idx + CW'(1);
            if (wr_idx == mid_idx) begin
              med <= emit;
            end
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          result_data.median     <= (wr_idx == mid_idx) ? carry : med;
          result_data.fill_count <= COUNT_BITS'(valid_count);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // Fill count never runs past the window length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= eff_len)
    else $error("fill count above window length");

  // The merged list has exactly one slot left for the carry at the end
  a_final_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |-> (wr_idx + CW'(1) == valid_count))
    else $error("merged list length mismatch");

  // The evicted value has been found before the pass ends
  a_removed: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |-> removed)
    else $error("evicted value not found in sorted list");

  // A new result only comes out of the final step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_FINAL))
    else $error("result raised outside final step");
`endif

endmodule

`default_nettype wire

// ===== src/rmf_ram.sv =====
// ----------------------------------------------------------------------------
// rmf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
